FILE: rtl/core/multipart_body_deframer_macros.svh
// ---------------------------------------------------------------------------
// multipart_body_deframer assertion macros
// Shorthands for clocked checks with the block's reset.
// ---------------------------------------------------------------------------
`ifndef MULTIPART_BODY_DEFRAMER_MACROS_SVH
`define MULTIPART_BODY_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MBD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("multipart_body_deframer check failed");

// Implication into the next cycle.
`define MBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("multipart_body_deframer check failed");

`else

`define MBD_ASSERT_NOW(label, ante, cons)
`define MBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/mbd_pkg.sv
// ---------------------------------------------------------------------------
// mbd_pkg
// Types and constants shared by the multipart body deframer modules.
// ---------------------------------------------------------------------------
package mbd_pkg;

	localparam int MBD_MAX_BOUNDARY = 32;
	localparam int HOLD_DEPTH       = 4;
	localparam int CMD_DEPTH        = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD0  = 3'd1;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_HY = 8'h2D;

	typedef enum logic [2:0] {
		KIND_HDR      = 3'd0,
		KIND_BODY     = 3'd1,
		KIND_HDR_END  = 3'd2,
		KIND_BODY_END = 3'd3,
		KIND_FIN      = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		PS_READY, PS_HY1, PS_BND, PS_AFTER_BND, PS_AFTER_CR, PS_CLOSE_HY,
		PS_CLOSE_HY2, PS_CLOSE_CR, PS_PART, PS_HDR, PS_HDR_CR, PS_EMPTY_CR,
		PS_BODY, PS_BODY_CR, PS_BODY_NL, PS_BODY_NL_CR, PS_DONE
	} pstate_t;

	// Configuration write as seen by the parser.
	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// One command per input byte that yields results. The second result,
	// when present, is always an event and carries a zero byte.
	typedef struct packed {
		logic       two;
		logic [7:0] bval0;
		kind_t      kind0;
		kind_t      kind1;
	} cmd_t;

endpackage

FILE: rtl/core/mbd_front.sv
// ---------------------------------------------------------------------------
// mbd_front
// Byte parser: boundary match, header and body tracking, body holdback.
// ---------------------------------------------------------------------------
module mbd_front import mbd_pkg::*; #(
	parameter int MAX_BOUNDARY = MBD_MAX_BOUNDARY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	localparam int IDX_W = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;

	logic [7:0]       bnd_q [MAX_BOUNDARY];
	logic [LEN_W-1:0] len_q;

	pstate_t          state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       hb_q [HOLD_DEPTH];
	logic [2:0]       hb_cnt_q;

	logic [LEN_W-1:0] used_len;
	logic             last_bnd;
	logic             hb_full;
	logic             body_push;
	logic             hb_clear;
	logic             emit;

	// Configuration storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg.wr && cfg.index == CFG_LENGTH) begin
			len_q <= cfg.data[LEN_W-1:0];
		end
	end

	for (genvar p = 0; p < MAX_BOUNDARY; p++) begin : g_bnd
		localparam int WordIdx = CFG_WORD0 + p / 8;
		localparam int Lane    = p % 8;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bnd_q[p] <= 8'h00;
			end else if (cfg.wr && cfg.index == CFG_IDX_W'(WordIdx)) begin
				bnd_q[p] <= cfg.data[8*Lane +: 8];
			end
		end
	end

	always_comb begin
		used_len = len_q;
		if (len_q == '0)
			used_len = LEN_W'(1);
		else if (len_q > LEN_W'(MAX_BOUNDARY))
			used_len = LEN_W'(MAX_BOUNDARY);
	end

	assign last_bnd = (7'(idx_q) + 7'd1) >= 7'(used_len);
	assign hb_full  = (hb_cnt_q == 3'(HOLD_DEPTH));

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		body_push = 1'b0;
		hb_clear  = 1'b0;
		emit      = 1'b0;
		cmd       = '{two: 1'b0, bval0: 8'h00, kind0: KIND_HDR, kind1: KIND_HDR_END};

		unique case (state_q)
			PS_READY: begin
				if (in_byte == CH_HY)
					state_d = PS_HY1;
			end
			PS_HY1: begin
				if (in_byte == CH_HY) begin
					state_d = PS_BND;
					idx_d   = '0;
				end else begin
					state_d = PS_READY;
				end
			end
			PS_BND: begin
				if (in_byte != bnd_q[idx_q]) begin
					state_d = PS_READY;
					idx_d   = '0;
				end else if (last_bnd) begin
					state_d = PS_AFTER_BND;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			PS_AFTER_BND: begin
				if (in_byte == CH_CR)
					state_d = PS_AFTER_CR;
				else if (in_byte == CH_HY)
					state_d = PS_CLOSE_HY;
			end
			PS_CLOSE_HY: state_d = (in_byte == CH_HY) ? PS_CLOSE_HY2 : PS_READY;
			PS_CLOSE_HY2: state_d = (in_byte == CH_CR) ? PS_CLOSE_CR : PS_READY;
			PS_CLOSE_CR: begin
				if (in_byte == CH_LF) begin
					state_d   = PS_DONE;
					emit      = 1'b1;
					cmd.kind0 = KIND_FIN;
				end else begin
					state_d = PS_READY;
				end
			end
			PS_AFTER_CR: state_d = (in_byte == CH_LF) ? PS_PART : PS_READY;
			PS_PART: begin
				if (in_byte != CH_CR) begin
					emit      = 1'b1;
					cmd.bval0 = in_byte;
					state_d   = PS_HDR;
				end else begin
					state_d = PS_EMPTY_CR;
				end
			end
			PS_HDR: begin
				emit      = 1'b1;
				cmd.bval0 = in_byte;
				if (in_byte == CH_CR)
					state_d = PS_HDR_CR;
			end
			PS_HDR_CR: begin
				emit      = 1'b1;
				cmd.bval0 = in_byte;
				state_d   = (in_byte == CH_LF) ? PS_PART : PS_HDR;
			end
			PS_EMPTY_CR: begin
				emit     = 1'b1;
				hb_clear = 1'b1;
				state_d  = PS_BODY;
				if (in_byte != CH_LF) begin
					cmd.two   = 1'b1;
					cmd.bval0 = in_byte;
				end else begin
					cmd.kind0 = KIND_HDR_END;
				end
			end
			PS_BODY, PS_BODY_CR, PS_BODY_NL, PS_BODY_NL_CR: begin
				body_push = 1'b1;
				if (hb_full) begin
					emit      = 1'b1;
					cmd.bval0 = hb_q[0];
					cmd.kind0 = KIND_BODY;
				end
				unique case (state_q)
					PS_BODY: begin
						if (in_byte == CH_CR)
							state_d = PS_BODY_CR;
					end
					PS_BODY_CR: begin
						if (in_byte == CH_LF)
							state_d = PS_BODY_NL;
						else if (in_byte != CH_CR)
							state_d = PS_BODY;
					end
					PS_BODY_NL: state_d = (in_byte == CH_CR) ? PS_BODY_NL_CR : PS_BODY;
					default: begin
						if (in_byte != CH_LF) begin
							state_d = PS_BODY;
						end else begin
							hb_clear = 1'b1;
							state_d  = PS_READY;
							emit     = 1'b1;
							if (hb_full) begin
								cmd.two   = 1'b1;
								cmd.kind1 = KIND_BODY_END;
							end else begin
								cmd.bval0 = 8'h00;
								cmd.kind0 = KIND_BODY_END;
							end
						end
					end
				endcase
			end
			PS_DONE: state_d = PS_DONE;
			default: state_d = PS_DONE;
		endcase
	end

	assign cmd_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PS_READY;
			idx_q    <= '0;
			hb_cnt_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (hb_clear)
				hb_cnt_q <= '0;
			else if (body_push && !hb_full)
				hb_cnt_q <= hb_cnt_q + 3'd1;
		end
	end

	// Holdback bytes are only read after they were written.
	always_ff @(posedge clk) begin
		if (accept && body_push) begin
			if (hb_full) begin
				for (int i = 0; i < HOLD_DEPTH - 1; i++)
					hb_q[i] <= hb_q[i+1];
				hb_q[HOLD_DEPTH-1] <= in_byte;
			end else begin
				hb_q[hb_cnt_q[1:0]] <= in_byte;
			end
		end
	end

endmodule

FILE: rtl/core/mbd_cmd_fifo.sv
// ---------------------------------------------------------------------------
// mbd_cmd_fifo
// Short command queue between the parser and the result stage.
// ---------------------------------------------------------------------------
module mbd_cmd_fifo import mbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(CMD_DEPTH);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (PTR_W+1)'(CMD_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/mbd_back.sv
// ---------------------------------------------------------------------------
// mbd_back
// Result stage: expands each command into one or two result transactions.
// ---------------------------------------------------------------------------
module mbd_back import mbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last_of_run
);

	cmd_t cur_q;
	logic valid_q;
	logic phase_q;
	logic done_cur;
	logic take;

	assign empty       = !valid_q;
	assign out_byte    = phase_q ? 8'h00 : cur_q.bval0;
	assign kind        = phase_q ? cur_q.kind1 : cur_q.kind0;
	assign last_of_run = phase_q || !cur_q.two;

	// The current command is finished when its last result is popped.
	assign done_cur = valid_q && pop && last_of_run;
	assign take     = !valid_q || done_cur;
	assign cmd_pop  = take && !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (take) begin
			valid_q <= !cmd_empty;
			phase_q <= 1'b0;
		end else if (pop) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd;
	end

endmodule

FILE: rtl/core/multipart_body_deframer.sv
// ---------------------------------------------------------------------------
// multipart_body_deframer
// Finds boundaries in a multipart byte stream and streams header and body
// bytes with header end, body end and finish events.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         push / full         data_byte
// result    out        pop / empty         out_byte, kind, last_of_run
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while the four-entry command queue has room.
// Results leave at one per cycle while pop is high and commands are waiting,
// through the single result register; a byte that yields two results holds it
// until both are popped. Each result passes the queue, then that register.
// full rises when the command queue holds four commands; bytes with no
// result never enter the queue. Configuration writes are always ready.
// Reset clears parser state, queue and result register; no clearing pass.
// ---------------------------------------------------------------------------
`include "multipart_body_deframer_macros.svh"

module multipart_body_deframer import mbd_pkg::*; #(
	parameter int MAX_BOUNDARY = MBD_MAX_BOUNDARY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            data_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            out_byte,
	output logic [2:0]            kind,
	output logic                  last_of_run,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_wr_t cfg;
	logic    accept;
	logic    cmd_push;
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_empty;
	logic    cmd_full;
	logic    cmd_pop;

	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign full   = cmd_full;
	assign accept = push && !full;

	mbd_front #(
		.MAX_BOUNDARY(MAX_BOUNDARY)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.in_byte (data_byte),
		.cmd_push(cmd_push),
		.cmd     (cmd_in)
	);

	mbd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty),
		.full   (cmd_full)
	);

	mbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.kind       (kind),
		.last_of_run(last_of_run)
	);

	// A command is never written into a full queue.
	`MBD_ASSERT_NOW(a_no_overflow, cmd_push, !cmd_full)
	// The finish event always stands alone.
	`MBD_ASSERT_NOW(a_fin_last, !empty && kind == KIND_FIN, last_of_run)
	// The first of two results is a data byte, and an end event follows it.
	`MBD_ASSERT_NEXT(a_pair_order, pop && !empty && !last_of_run,
		!empty && last_of_run && (kind == KIND_HDR_END || kind == KIND_BODY_END))

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Feeds multipart byte streams into the deframer with random idle gaps on
// both sides and checks every result against a cycle-free parser model.
// ---------------------------------------------------------------------------
module testbench;
	import mbd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_WORD0 + 3'd4;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS     = 140;

	typedef struct packed {
		logic [7:0] val;
		kind_t      kind;
		logic       last;
	} part_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            data_byte = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            out_byte;
	logic [2:0]            kind;
	logic                  last_of_run;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Parser model state and its copy of the boundary registers.
	logic [LEN_W-1:0]      bnd_len;
	logic [CFG_DATA_W-1:0] bnd_word [4];
	pstate_t               parse_st;
	logic [4:0]            match_idx;
	logic [7:0]            holdback [4];
	logic [2:0]            held;

	logic [7:0]   stream_q [$];
	part_result_t expected_q [$];
	part_result_t oldest;
	int unsigned  stream_len;
	int unsigned  mismatches = 0;
	int unsigned  send_gap = 0;
	int unsigned  pop_wait = 0;
	bit           long_hold_armed = 1'b0;
	bit           hold_done = 1'b0;
	bit           quiet_tail = 1'b0;

	multipart_body_deframer DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int used_len();
		if (bnd_len == 0)
			return 1;
		if (bnd_len > MBD_MAX_BOUNDARY)
			return MBD_MAX_BOUNDARY;
		return int'(bnd_len);
	endfunction

	function automatic logic [7:0] bnd_byte(input int idx);
		return bnd_word[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic part_result_t make_result(input logic [7:0] v, input kind_t k);
		part_result_t r;
		r = '{val: v, kind: k, last: 1'b0};
		return r;
	endfunction

	// Shifts a body byte into the holdback; bit 8 flags a byte pushed out.
	function automatic logic [8:0] hold_body(input logic [7:0] b);
		logic [8:0] spill;
		spill = '0;
		if (held >= HOLD_DEPTH) begin
			spill = {1'b1, holdback[0]};
			holdback[0] = holdback[1];
			holdback[1] = holdback[2];
			holdback[2] = holdback[3];
			holdback[3] = b;
		end else begin
			holdback[held[1:0]] = b;
			held = held + 3'd1;
		end
		return spill;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		part_result_t res [$];
		logic [8:0]   spill;
		if (parse_st inside {PS_BODY, PS_BODY_CR, PS_BODY_NL, PS_BODY_NL_CR}) begin
			spill = hold_body(b);
			if (spill[8])
				res.push_back(make_result(spill[7:0], KIND_BODY));
		end
		case (parse_st)
		PS_READY: begin
			if (b == CH_HY)
				parse_st = PS_HY1;
		end
		PS_HY1: begin
			if (b == CH_HY) begin
				parse_st = PS_BND;
				match_idx = '0;
			end else
				parse_st = PS_READY;
		end
		PS_BND: begin
			if (b != bnd_byte(int'(match_idx))) begin
				parse_st = PS_READY;
				match_idx = '0;
			end else if (int'(match_idx) + 1 >= used_len()) begin
				parse_st = PS_AFTER_BND;
				match_idx = '0;
			end else
				match_idx = match_idx + 5'd1;
		end
		PS_AFTER_BND: begin
			if (b == CH_CR)
				parse_st = PS_AFTER_CR;
			else if (b == CH_HY)
				parse_st = PS_CLOSE_HY;
		end
		PS_CLOSE_HY: begin
			if (b == CH_HY)
				parse_st = PS_CLOSE_HY2;
			else
				parse_st = PS_READY;
		end
		PS_CLOSE_HY2: begin
			if (b == CH_CR)
				parse_st = PS_CLOSE_CR;
			else
				parse_st = PS_READY;
		end
		PS_CLOSE_CR: begin
			if (b == CH_LF) begin
				parse_st = PS_DONE;
				res.push_back(make_result(8'h00, KIND_FIN));
			end else
				parse_st = PS_READY;
		end
		PS_AFTER_CR: begin
			if (b == CH_LF)
				parse_st = PS_PART;
			else
				parse_st = PS_READY;
		end
		PS_PART: begin
			if (b != CH_CR) begin
				res.push_back(make_result(b, KIND_HDR));
				parse_st = PS_HDR;
			end else
				parse_st = PS_EMPTY_CR;
		end
		PS_HDR: begin
			res.push_back(make_result(b, KIND_HDR));
			if (b == CH_CR)
				parse_st = PS_HDR_CR;
		end
		PS_HDR_CR: begin
			res.push_back(make_result(b, KIND_HDR));
			if (b == CH_LF)
				parse_st = PS_PART;
			else
				parse_st = PS_HDR;
		end
		PS_EMPTY_CR: begin
			if (b != CH_LF)
				res.push_back(make_result(b, KIND_HDR));
			res.push_back(make_result(8'h00, KIND_HDR_END));
			held = '0;
			parse_st = PS_BODY;
		end
		PS_BODY: begin
			if (b == CH_CR)
				parse_st = PS_BODY_CR;
		end
		PS_BODY_CR: begin
			if (b == CH_LF)
				parse_st = PS_BODY_NL;
			else if (b != CH_CR)
				parse_st = PS_BODY;
		end
		PS_BODY_NL: begin
			if (b == CH_CR)
				parse_st = PS_BODY_NL_CR;
			else
				parse_st = PS_BODY;
		end
		PS_BODY_NL_CR: begin
			if (b != CH_LF)
				parse_st = PS_BODY;
			else begin
				held = '0;
				res.push_back(make_result(8'h00, KIND_BODY_END));
				parse_st = PS_READY;
			end
		end
		default: parse_st = PS_DONE;
		endcase
		if (res.size() > 0)
			res[res.size() - 1].last = 1'b1;
		foreach (res[i])
			expected_q.push_back(res[i]);
	endtask

	// Byte source: one transaction per accepted byte, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap <= 0;
		end else begin
			if (push && !full) begin
				parse_byte(data_byte);
				void'(stream_q.pop_front());
			end
			if (push && full) begin
				// Hold the offered byte until the block takes it.
			end else if (send_gap != 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stream_q.size() == 0) begin
				push <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				push <= 1'b0;
				send_gap <= $urandom_range(0, 12);
			end else begin
				push <= 1'b1;
				data_byte <= stream_q[0];
			end
		end
	end

	// Result sink: compares each popped result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: out_byte %02h kind %0d", out_byte, kind);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					if (out_byte !== oldest.val) begin
						$error("out_byte: expected %02h, got %02h", oldest.val, out_byte);
						mismatches++;
					end
					if (kind !== oldest.kind) begin
						$error("kind: expected %0d, got %0d", oldest.kind, kind);
						mismatches++;
					end
					if (last_of_run !== oldest.last) begin
						$error("last_of_run: expected %0b, got %0b", oldest.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (long_hold_armed && !hold_done) begin
				hold_done <= 1'b1;
				pop_wait <= HOLD_OFF_CYCLES;
				pop <= 1'b0;
			end else if (pop_wait != 0) begin
				pop_wait <= pop_wait - 1;
				pop <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				pop_wait <= $urandom_range(0, 12);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic put(input logic [7:0] b);
		stream_q.push_back(b);
		stream_len++;
	endtask

	function automatic logic [7:0] any_but(input logic [7:0] x);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == x);
		return b;
	endfunction

	function automatic logic [7:0] rand_body_byte();
		case ($urandom_range(0, 9))
		0: return CH_CR;
		1: return CH_LF;
		2: return CH_HY;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Dashes, boundary and sometimes junk that the parser skips.
	task automatic put_boundary();
		logic [7:0] b;
		put(CH_HY);
		put(CH_HY);
		for (int i = 0; i < used_len(); i++)
			put(bnd_byte(i));
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_HY);
				put(b);
			end
		end
	endtask

	task automatic put_part();
		put_boundary();
		put(CH_CR);
		put(CH_LF);
		repeat ($urandom_range(0, 3)) begin
			put(any_but(CH_CR));
			repeat ($urandom_range(0, 9))
				put(($urandom_range(0, 15) == 0) ? CH_CR : any_but(CH_CR));
			put(CH_CR);
			put(CH_LF);
		end
		put(CH_CR);
		put(($urandom_range(0, 7) == 0) ? any_but(CH_LF) : CH_LF);
		repeat ($urandom_range(0, 20))
			put(rand_body_byte());
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
	endtask

	task automatic put_broken();
		int k;
		logic [7:0] b;
		case ($urandom_range(0, 3))
		0: begin
			// Plain noise between parts.
			repeat ($urandom_range(1, 6))
				put(rand_body_byte());
		end
		1: begin
			k = $urandom_range(0, used_len() - 1);
			put(CH_HY);
			put(CH_HY);
			for (int i = 0; i < k; i++)
				put(bnd_byte(i));
			b = ($urandom_range(0, 1) == 0) ? CH_HY : any_but(bnd_byte(k));
			if (b == bnd_byte(k))
				b = ~b;
			put(b);
		end
		2: begin
			put_boundary();
			put(CH_HY);
			if ($urandom_range(0, 2) == 0)
				put(any_but(CH_HY));
			else begin
				put(CH_HY);
				if ($urandom_range(0, 1) == 0)
					put(any_but(CH_CR));
				else begin
					put(CH_CR);
					put(any_but(CH_LF));
				end
			end
		end
		default: begin
			put_boundary();
			put(CH_CR);
			put(any_but(CH_LF));
		end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_LENGTH)
			bnd_len = val[LEN_W-1:0];
		else if (idx >= CFG_WORD0 && idx < CFG_SPARE)
			bnd_word[idx - CFG_WORD0] = val;
	endtask

	task automatic configure(input logic [LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] w0);
		@(posedge clk);
		write_reg(CFG_LENGTH, CFG_DATA_W'(len));
		write_reg(CFG_WORD0, w0);
		for (int k = 1; k < 4; k++)
			write_reg(CFG_WORD0 + CFG_IDX_W'(k), {$urandom, $urandom});
		// Writes to indexes past the last word must change nothing.
		if ($urandom_range(0, 1) == 0)
			write_reg(CFG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (stream_q.size() != 0 || push || expected_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		bnd_len = 1;
		foreach (bnd_word[i])
			bnd_word[i] = '0;
		parse_st = PS_READY;
		match_idx = '0;
		held = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the one-byte boundary "x".
		configure(6'd1, 64'h78);
		put_boundary();
		put(CH_CR);
		put(CH_LF);
		put(8'h00);
		put(CH_CR);
		put(8'h7F);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		put(8'hFF);
		put(8'h80);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		// A stray byte after the empty-line CR, then an empty body.
		put_boundary();
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(8'h5A);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		wait_idle();

		// Shorten the boundary while a match is in progress.
		configure(6'd10, {$urandom, $urandom});
		put(CH_HY);
		put(CH_HY);
		for (int i = 0; i < 6; i++)
			put(bnd_byte(i));
		wait_idle();
		@(posedge clk);
		write_reg(CFG_LENGTH, CFG_DATA_W'(4));
		cfg_valid <= 1'b0;
		put(bnd_byte(6));
		put(CH_CR);
		put(CH_LF);
		put(8'h41);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		put(8'h42);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: len = 6'd0;
			1: len = 6'd32;
			2: len = 6'd63;
			3: len = LEN_W'($urandom_range(33, 62));
			4: len = 6'd1;
			default: len = LEN_W'($urandom_range(1, 32));
			endcase
			configure(len, {$urandom, $urandom});
			if (ph == 1)
				long_hold_armed = 1'b1;
			if (ph == 7)
				quiet_tail = 1'b1;
			stream_len = 0;
			while (stream_len < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					put_broken();
				else
					put_part();
			end
			if (ph == 7) begin
				// Closing delimiter; the bytes after it must be ignored.
				put_boundary();
				put(CH_HY);
				put(CH_HY);
				put(CH_CR);
				put(CH_LF);
				put(CH_HY);
				put(CH_HY);
				repeat (4)
					put(rand_body_byte());
			end
			wait_idle();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("[multipart_body_deframer] OK");
		else
			$display("[multipart_body_deframer] ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[multipart_body_deframer] ERROR");
		$finish;
	end

endmodule
